FILE: hw/rtl/tam_pkg.sv
// Shared types, constants and helpers of the temperature alert monitor.
// No dependencies; every other file of the block imports this package.
package tam_pkg;

  localparam int unsigned COUNT_BITS    = 16;
  localparam int unsigned LightLimit    = 5;
  localparam int unsigned ModerateLimit = 10;
  localparam int unsigned DivSteps      = 32;
  localparam int unsigned DivStepW      = $clog2(DivSteps);
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned InDataW       = 16;
  localparam int unsigned OutDataW      = 184;
  localparam int unsigned AddrW         = 4;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [29:0] SecondsMax = '1;

  typedef enum logic {
    OpMeasure = 1'b0,
    OpReport  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    LvlNormal   = 2'd0,
    LvlLight    = 2'd1,
    LvlModerate = 2'd2,
    LvlCritical = 2'd3
  } level_e;

  typedef enum logic [1:0] {
    RegBandLow   = 2'd0,
    RegBandHigh  = 2'd1,
    RegAlarmRun  = 2'd2,
    RegPeriod    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackDiv,
    BackDone
  } back_state_e;

  typedef struct packed {
    logic signed [7:0] band_low;
    logic signed [7:0] band_high;
    logic [15:0]       alarm_run;
    logic [11:0]       sample_period;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    level_e             level;
    logic signed [15:0] temp;
  } q_item_t;

  typedef struct packed {
    logic [1:0]         alert_level;
    logic [15:0]        run_length;
    logic               alarm;
    logic signed [15:0] min_temp;
    logic signed [15:0] max_temp;
    logic signed [15:0] mean_temp;
    logic [15:0]        total_samples;
    logic [15:0]        light_alerts;
    logic [15:0]        moderate_alerts;
    logic [15:0]        critical_alerts;
    logic [29:0]        alert_seconds;
  } result_t;

  // queue output to the back end: valid flag and item
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_out_t;

  function automatic logic [15:0] clip16(input logic [COUNT_BITS-1:0] v);
    logic [15:0] r;
    if (33'(v) > 33'h0_FFFF) r = 16'hFFFF;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS-1:0] r;
    if (v == CountMax) r = v;
    else r = v + 1'b1;
    return r;
  endfunction

endpackage

FILE: hw/rtl/tam_front.sv
// Front end: takes input transfers, rates the sample against the band.
// Depends on tam_pkg; feeds tam_queue.
module tam_front (
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic                 op_i,
  input  logic signed [15:0]   temp_i,
  input  tam_pkg::cfg_t        cfg_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tam_pkg::q_item_t     q_item_o
);
  import tam_pkg::*;

  logic signed [17:0] t_w, lo_w, hi_w, dist_w;
  logic               above_w, below_w;
  level_e             level_w;

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  always_comb begin
    t_w     = 18'(temp_i);
    lo_w    = 18'($signed({cfg_i.band_low, 8'h00}));
    hi_w    = 18'($signed({cfg_i.band_high, 8'h00}));
    above_w = t_w > hi_w;
    below_w = t_w < lo_w;
    // inverted band: above wins, otherwise measured from band_low
    dist_w  = above_w ? (t_w - hi_w) : (lo_w - t_w);
    if (!(above_w || below_w)) level_w = LvlNormal;
    else if (dist_w < 18'(LightLimit * 256)) level_w = LvlLight;
    else if (dist_w < 18'(ModerateLimit * 256)) level_w = LvlModerate;
    else level_w = LvlCritical;
  end

  always_comb begin
    q_item_o.op    = op_e'(op_i);
    q_item_o.level = (op_e'(op_i) == OpMeasure) ? level_w : LvlNormal;
    q_item_o.temp  = temp_i;
  end

endmodule

FILE: hw/rtl/tam_queue.sv
// Short FIFO between the classifying front and the statistics back end.
// Depends on tam_pkg for the item type and depth.
module tam_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tam_pkg::q_item_t  item_i,
  output logic              full_o,
  input  logic              pop_i,
  output tam_pkg::q_out_t   out_o
);
  import tam_pkg::*;

  q_item_t              mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   fill_q, fill_d;
  logic                 do_push, do_pop;

  assign full_o     = fill_q == (QueuePtrW+1)'(QueueDepth);
  assign out_o.valid = fill_q != '0;
  assign out_o.item  = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && out_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) fill_d = fill_q + 1'b1;
    else if (do_pop && !do_push) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

FILE: hw/rtl/tam_back.sv
// Back end: statistics state, run/alarm tracking, serial mean divider,
// duration multiply and the output register. Depends on tam_pkg.
module tam_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tam_pkg::cfg_t     cfg_i,
  input  tam_pkg::q_out_t   q_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tam_pkg::result_t  out_o
);
  import tam_pkg::*;

  back_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] run_q, total_q;
  logic [COUNT_BITS-1:0] cnt_q [3];
  logic signed [15:0]    low_q, high_q;
  logic signed [31:0]    sum_q;

  logic [COUNT_BITS-1:0] rem_q;
  logic [31:0]           quo_q;
  logic [DivStepW-1:0]   step_q;
  logic                  neg_q;
  logic [29:0]           secs_q;

  result_t res_q, res_d;
  logic    out_valid_q;

  logic out_free, any_w, last_step;
  logic load_meas, load_empty, div_start, load_rep;

  // measure datapath
  level_e                lvl_w;
  logic signed [15:0]    t_w;
  logic [COUNT_BITS-1:0] run_nx, total_nx;
  logic [COUNT_BITS-1:0] cnt_nx [3];
  logic signed [15:0]    low_nx, high_nx;
  logic signed [31:0]    sum_nx;
  logic [32:0]           sum_ext;
  logic                  alarm_w;

  // report datapath
  logic [COUNT_BITS+1:0]  lvl_total;
  logic [COUNT_BITS+13:0] prod_w;
  logic [29:0]            secs_w;
  logic [31:0]            mag_w, mean_full;
  logic [COUNT_BITS:0]    rem_sh, rem_sub;
  logic                   ge_w;

  assign out_free    = !out_valid_q || out_ready_i;
  assign any_w       = total_q != '0;
  assign last_step   = step_q == DivStepW'(DivSteps - 1);
  assign out_valid_o = out_valid_q;
  assign out_o       = res_q;
  assign lvl_w       = q_i.item.level;
  assign t_w         = q_i.item.temp;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BackIdle: if (q_i.valid && out_free && q_i.item.op == OpReport && any_w)
                  state_d = BackDiv;
      BackDiv:  if (last_step) state_d = BackDone;
      BackDone: if (out_free) state_d = BackIdle;
      default:  state_d = BackIdle;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o      = 1'b0;
    load_meas  = 1'b0;
    load_empty = 1'b0;
    div_start  = 1'b0;
    load_rep   = 1'b0;
    unique case (state_q)
      BackIdle: begin
        pop_o      = q_i.valid && out_free;
        load_meas  = pop_o && q_i.item.op == OpMeasure;
        load_empty = pop_o && q_i.item.op == OpReport && !any_w;
        div_start  = pop_o && q_i.item.op == OpReport && any_w;
      end
      BackDone: load_rep = out_free;
      default: ;
    endcase
  end

  // measure update
  always_comb begin
    for (int i = 0; i < 3; i++) cnt_nx[i] = cnt_q[i];
    unique case (lvl_w)
      LvlLight:    cnt_nx[0] = sat_inc(cnt_q[0]);
      LvlModerate: cnt_nx[1] = sat_inc(cnt_q[1]);
      LvlCritical: cnt_nx[2] = sat_inc(cnt_q[2]);
      default: ;
    endcase
    run_nx  = (lvl_w != LvlNormal) ? sat_inc(run_q) : '0;
    alarm_w = (lvl_w != LvlNormal) && (33'(run_nx) >= 33'(cfg_i.alarm_run));
    low_nx  = (t_w < low_q) ? t_w : low_q;
    high_nx = (t_w > high_q) ? t_w : high_q;
    sum_ext = {sum_q[31], sum_q} + {{17{t_w[15]}}, t_w};
    if (sum_ext[32] != sum_ext[31]) sum_nx = sum_ext[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sum_nx = $signed(sum_ext[31:0]);
    // once the count is full the sum freezes so the mean stays consistent
    if (total_q != CountMax) begin
      total_nx = total_q + 1'b1;
    end else begin
      total_nx = total_q;
      sum_nx   = sum_q;
    end
  end

  // report helpers
  always_comb begin
    lvl_total = (COUNT_BITS+2)'(cnt_q[0]) + (COUNT_BITS+2)'(cnt_q[1])
              + (COUNT_BITS+2)'(cnt_q[2]);
    prod_w    = (COUNT_BITS+14)'(lvl_total) * (COUNT_BITS+14)'(cfg_i.sample_period);
    secs_w    = ((COUNT_BITS+14)'(prod_w) > (COUNT_BITS+14)'(SecondsMax)) ? SecondsMax
                                                                        : 30'(prod_w);
    mag_w     = sum_q[31] ? (32'd0 - sum_q) : sum_q;
    rem_sh    = {rem_q, quo_q[31]};
    ge_w      = rem_sh >= {1'b0, total_q};
    rem_sub   = ge_w ? (rem_sh - {1'b0, total_q}) : rem_sh;
    mean_full = neg_q ? (32'd0 - quo_q) : quo_q;
  end

  always_comb begin
    res_d = res_q;
    if (load_meas) begin
      res_d.alert_level     = lvl_w;
      res_d.run_length      = clip16(run_nx);
      res_d.alarm           = alarm_w;
      res_d.min_temp        = low_nx;
      res_d.max_temp        = high_nx;
      res_d.mean_temp       = '0;
      res_d.total_samples   = clip16(total_nx);
      res_d.light_alerts    = clip16(cnt_nx[0]);
      res_d.moderate_alerts = clip16(cnt_nx[1]);
      res_d.critical_alerts = clip16(cnt_nx[2]);
      res_d.alert_seconds   = '0;
    end else if (load_empty || load_rep) begin
      res_d.alert_level     = LvlNormal;
      res_d.run_length      = clip16(run_q);
      res_d.alarm           = 1'b0;
      res_d.min_temp        = any_w ? low_q : '0;
      res_d.max_temp        = any_w ? high_q : '0;
      res_d.mean_temp       = load_rep ? $signed(mean_full[15:0]) : '0;
      res_d.total_samples   = clip16(total_q);
      res_d.light_alerts    = clip16(cnt_q[0]);
      res_d.moderate_alerts = clip16(cnt_q[1]);
      res_d.critical_alerts = clip16(cnt_q[2]);
      res_d.alert_seconds   = load_rep ? secs_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BackIdle;
      out_valid_q <= 1'b0;
      run_q       <= '0;
      total_q     <= '0;
      low_q       <= 16'sh7FFF;
      high_q      <= 16'sh8000;
      sum_q       <= '0;
      for (int i = 0; i < 3; i++) cnt_q[i] <= '0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (load_meas || load_empty || load_rep) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (load_meas) begin
        run_q   <= run_nx;
        total_q <= total_nx;
        low_q   <= low_nx;
        high_q  <= high_nx;
        sum_q   <= sum_nx;
        for (int i = 0; i < 3; i++) cnt_q[i] <= cnt_nx[i];
      end
      if (div_start) step_q <= '0;
      else if (state_q == BackDiv) step_q <= step_q + 1'b1;
    end
  end

  // divider and payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (div_start) begin
      rem_q  <= '0;
      quo_q  <= mag_w;
      neg_q  <= sum_q[31];
      secs_q <= secs_w;
    end else if (state_q == BackDiv) begin
      rem_q <= rem_sub[COUNT_BITS-1:0];
      quo_q <= {quo_q[30:0], ge_w};
    end
  end

endmodule

FILE: hw/rtl/temperature_alert_monitor.sv
// Temperature alert monitor: classifies Q8.8 samples against a band and keeps
// alert statistics; a report transfer returns mean, alert time, min and max.
// Input transfers on s_axis: tuser selects measure (0) or report (1), tdata
// carries the Q8.8 sample. One result transfer per input on m_axis.
// Configuration over APB: band_low 0x0, band_high 0x4, alarm_run 0x8,
// sample_period 0xC; write only while no transfer is in flight.
// A measure passes through the queue and then the output register of the back
// end, one measure per cycle when the sink keeps up. A report with samples
// runs the restoring divider, which retires one quotient bit per cycle over
// 32 bits; the back end takes nothing from the queue while it runs. An empty
// report is loaded straight into the output register.
// Reset clears statistics and loads the register defaults (15, 35, 3, 1).
// When the sink stalls the result holds in the output register and the
// two-entry queue keeps accepting input until it fills, then tready drops.
module temperature_alert_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tam_pkg::InDataW-1:0]    s_axis_tdata,  // [15:0] temp_sample
  input  logic                           s_axis_tuser,  // [0] operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] alert_level, [17:2] run_length, [18] alarm, [34:19] min_temp,
  // [50:35] max_temp, [66:51] mean_temp, [82:67] total_samples,
  // [98:83] light_alerts, [114:99] moderate_alerts, [130:115] critical_alerts,
  // [160:131] alert_seconds, [183:161] zero
  output logic [tam_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tam_pkg::AddrW-1:0]      paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tam_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e wr_idx;
  logic     q_full, q_push, q_pop;
  q_item_t  q_item;
  q_out_t   q_out;
  result_t  res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_low      <= 8'sd15;
      cfg_q.band_high     <= 8'sd35;
      cfg_q.alarm_run     <= 16'd3;
      cfg_q.sample_period <= 12'd1;
    end else if (wr_en) begin
      unique case (wr_idx)
        RegBandLow:  cfg_q.band_low      <= $signed(pwdata[7:0]);
        RegBandHigh: cfg_q.band_high     <= $signed(pwdata[7:0]);
        RegAlarmRun: cfg_q.alarm_run     <= pwdata[15:0];
        RegPeriod:   cfg_q.sample_period <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      RegBandLow:  prdata = {24'd0, cfg_q.band_low};
      RegBandHigh: prdata = {24'd0, cfg_q.band_high};
      RegAlarmRun: prdata = {16'd0, cfg_q.alarm_run};
      RegPeriod:   prdata = {20'd0, cfg_q.sample_period};
      default:     prdata = '0;
    endcase
  end

  tam_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (s_axis_tuser),
    .temp_i    ($signed(s_axis_tdata[15:0])),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (q_item)
  );

  tam_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .out_o  (q_out)
  );

  tam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_i         (q_out),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {23'd0, res.alert_seconds, res.critical_alerts,
                         res.moderate_alerts, res.light_alerts, res.total_samples,
                         res.mean_temp, res.max_temp, res.min_temp, res.alarm,
                         res.run_length, res.alert_level};

endmodule

FILE: bench/tam_result_checker.sv
// Result checker for the temperature alert monitor: follows the APB register
// writes and the input stream, predicts each result and compares it with the
// output stream. Depends on tam_pkg.
module tam_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [tam_pkg::InDataW-1:0]   s_tdata_i,   // [15:0] temp_sample
  input  logic                          s_tuser_i,   // [0] operation
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [tam_pkg::OutDataW-1:0]  m_tdata_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [tam_pkg::AddrW-1:0]     paddr_i,
  input  logic [31:0]                   pwdata_i,
  output int                            mismatches_o,
  output int                            awaited_o
);
  import tam_pkg::*;

  localparam int     LightSpan    = int'(LightLimit) * 256;
  localparam int     ModerateSpan = int'(ModerateLimit) * 256;
  localparam longint SumTop       = 64'sd2147483647;
  localparam longint SumBottom    = -64'sd2147483648;
  localparam longint SecondsTop   = (64'sd1 <<< 30) - 1;
  localparam logic [COUNT_BITS-1:0] CountFull = '1;

  // register copies
  logic signed [7:0]       band_lo, band_hi;
  logic [15:0]             run_needed;
  logic [11:0]             period_s;

  // statistics
  logic [COUNT_BITS-1:0]   streak, samples;
  logic [COUNT_BITS-1:0]   tally [3];
  logic signed [15:0]      coldest, hottest;
  longint                  temp_sum;

  result_t                 awaited_results [$];
  result_t                 want, got;

  function automatic logic [15:0] shown_count(input logic [COUNT_BITS-1:0] v);
    return (64'(v) > 64'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == CountFull) ? v : v + 1'b1;
  endfunction

  // classify one sample or build a report, updating the statistics
  task automatic rate_sample(input op_e op, input logic signed [15:0] t,
                             output result_t r);
    int     lo, hi, excess;
    level_e lvl;
    longint avg, alerts, secs;
    r   = '0;
    lvl = LvlNormal;
    if (op == OpMeasure) begin
      lo = int'(band_lo) * 256;
      hi = int'(band_hi) * 256;
      if (!(int'(t) >= lo && int'(t) <= hi)) begin
        // inverted band: above the upper bound counts from it, else from the lower
        excess = (int'(t) > hi) ? int'(t) - hi : lo - int'(t);
        if (excess < LightSpan) lvl = LvlLight;
        else if (excess < ModerateSpan) lvl = LvlModerate;
        else lvl = LvlCritical;
      end
      if (lvl != LvlNormal) begin
        streak = bump(streak);
        tally[int'(lvl) - 1] = bump(tally[int'(lvl) - 1]);
      end else begin
        streak = '0;
      end
      r.alarm = (lvl != LvlNormal) && (64'(streak) >= 64'(run_needed));
      if (t < coldest) coldest = t;
      if (t > hottest) hottest = t;
      // sum stops with the count so the mean stays consistent
      if (samples != CountFull) begin
        samples  = samples + 1'b1;
        temp_sum = temp_sum + longint'(t);
        if (temp_sum > SumTop) temp_sum = SumTop;
        if (temp_sum < SumBottom) temp_sum = SumBottom;
      end
    end else if (samples != 0) begin
      avg    = temp_sum / longint'(samples);
      alerts = longint'(tally[0]) + longint'(tally[1]) + longint'(tally[2]);
      secs   = alerts * longint'(period_s);
      r.mean_temp     = avg[15:0];
      r.alert_seconds = (secs > SecondsTop) ? 30'h3FFF_FFFF : secs[29:0];
    end
    r.alert_level     = lvl;
    r.run_length      = shown_count(streak);
    r.min_temp        = (samples != 0) ? coldest : 16'sd0;
    r.max_temp        = (samples != 0) ? hottest : 16'sd0;
    r.total_samples   = shown_count(samples);
    r.light_alerts    = shown_count(tally[0]);
    r.moderate_alerts = shown_count(tally[1]);
    r.critical_alerts = shown_count(tally[2]);
  endtask

  function automatic result_t unpack_result(input logic [OutDataW-1:0] d);
    result_t r;
    r.alert_level     = d[1:0];
    r.run_length      = d[17:2];
    r.alarm           = d[18];
    r.min_temp        = d[34:19];
    r.max_temp        = d[50:35];
    r.mean_temp       = d[66:51];
    r.total_samples   = d[82:67];
    r.light_alerts    = d[98:83];
    r.moderate_alerts = d[114:99];
    r.critical_alerts = d[130:115];
    r.alert_seconds   = d[160:131];
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_lo    <= 8'sd15;
      band_hi    <= 8'sd35;
      run_needed <= 16'd3;
      period_s   <= 12'd1;
      streak     = '0;
      samples    = '0;
      tally[0]   = '0;
      tally[1]   = '0;
      tally[2]   = '0;
      coldest    = 16'sh7FFF;
      hottest    = 16'sh8000;
      temp_sum   = 0;
      awaited_results.delete();
      mismatches_o = 0;
      awaited_o    = 0;
    end else begin
      // output first, so a stray result is never matched to this edge's input
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer, expected none, actual %h", $time, m_tdata_i);
          mismatches_o++;
        end else begin
          want = awaited_results.pop_front();
          got  = unpack_result(m_tdata_i);
          compare_field("alert_level", 32'(want.alert_level), 32'(got.alert_level));
          compare_field("run_length", 32'(want.run_length), 32'(got.run_length));
          compare_field("alarm", 32'(want.alarm), 32'(got.alarm));
          compare_field("min_temp", 32'(want.min_temp), 32'(got.min_temp));
          compare_field("max_temp", 32'(want.max_temp), 32'(got.max_temp));
          compare_field("mean_temp", 32'(want.mean_temp), 32'(got.mean_temp));
          compare_field("total_samples", 32'(want.total_samples),
                        32'(got.total_samples));
          compare_field("light_alerts", 32'(want.light_alerts), 32'(got.light_alerts));
          compare_field("moderate_alerts", 32'(want.moderate_alerts),
                        32'(got.moderate_alerts));
          compare_field("critical_alerts", 32'(want.critical_alerts),
                        32'(got.critical_alerts));
          compare_field("alert_seconds", 32'(want.alert_seconds),
                        32'(got.alert_seconds));
          compare_field("padding", 32'd0, 32'(m_tdata_i[OutDataW-1:161]));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[AddrW-1:2]))
          RegBandLow:  band_lo    <= pwdata_i[7:0];
          RegBandHigh: band_hi    <= pwdata_i[7:0];
          RegAlarmRun: run_needed <= pwdata_i[15:0];
          RegPeriod:   period_s   <= pwdata_i[11:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        rate_sample(op_e'(s_tuser_i), s_tdata_i, want);
        awaited_results.push_back(want);
      end
      awaited_o = awaited_results.size();
    end
  end

endmodule

FILE: bench/tb_temperature_alert_monitor.sv
// Testbench top for the temperature alert monitor: clock, reset, APB register
// setup, bursty sample stream and a stalling result sink; verdict at the end.
// Depends on tam_pkg, temperature_alert_monitor and tam_result_checker.
module tb_temperature_alert_monitor;
  import tam_pkg::*;

  localparam int StallLimit = 2000;
  localparam int EdgeSteps [8] = '{0, 1, 1279, 1280, 1281, 2559, 2560, 2561};

  typedef bit bool_streak_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // [15:0] temp_sample
  logic                 s_axis_tuser;   // [0] operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // result fields, alert_level in the lowest bits
  logic                 psel, penable, pwrite, pready;
  logic [AddrW-1:0]     paddr;
  logic [31:0]          pwdata, prdata;

  int mismatches;
  int awaited;
  int cur_low, cur_high;

  temperature_alert_monitor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tam_result_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [15:0] clamp_q88(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // mostly near a band edge, sometimes exactly on a level threshold
  function automatic logic signed [15:0] any_temp();
    int e, step;
    e    = ($urandom_range(0, 1) == 1) ? cur_low * 256 : cur_high * 256;
    step = EdgeSteps[$urandom_range(0, 7)];
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom);
      3:       return clamp_q88(($urandom_range(0, 1) == 1) ? e + step : e - step);
      default: return clamp_q88(e + int'($urandom_range(0, 6000)) - 3000);
    endcase
  endfunction

  function automatic logic signed [15:0] outside_temp();
    if ($urandom_range(0, 1) == 1)
      return clamp_q88(cur_high * 256 + 1 + int'($urandom_range(0, 4000)));
    return clamp_q88(cur_low * 256 - 1 - int'($urandom_range(0, 4000)));
  endfunction

  // entered and left at a falling edge; tvalid stays up for a following item
  task automatic send_item(input op_e op, input logic signed [15:0] t, input int gap);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = t;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_thresholds(input int lo, input int hi, input int run, input int period);
    settle();
    write_register(RegBandLow, 32'(8'(lo)));
    write_register(RegBandHigh, 32'(8'(hi)));
    write_register(RegAlarmRun, 32'(16'(run)));
    write_register(RegPeriod, 32'(12'(period)));
    cur_low  = lo;
    cur_high = hi;
  endtask

  task automatic random_phase(input int n_items);
    int  sent, burst, gap;
    bool_streak_t streak;
    op_e op;
    sent = 0;
    while (sent < n_items) begin
      burst  = $urandom_range(1, 24);
      gap    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      streak = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 49) == 0) settle();
      for (int i = 0; i < burst && sent < n_items; i++) begin
        op = ($urandom_range(0, 11) == 0) ? OpReport : OpMeasure;
        send_item(op, streak ? outside_temp() : any_temp(), (i == 0) ? gap : 0);
        sent++;
      end
    end
  endtask

  // result sink: stall pattern switches at random among four modes
  initial begin
    int mode, left, tick;
    m_axis_tready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      tick++;
      case (mode)
        0:       m_axis_tready = 1'b1;
        1:       m_axis_tready = 1'($urandom_range(0, 1));
        2:       m_axis_tready = ($urandom_range(0, 7) == 0);
        default: m_axis_tready = ((tick % 5) > 1);
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpMeasure;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cur_low       = 15;
    cur_high      = 35;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // default band 15..35 degrees, alarm after three alert samples
    send_item(OpReport, 16'sh0000, 0);     // nothing taken yet
    send_item(OpMeasure, 16'sd6400, 0);
    send_item(OpMeasure, 16'sd8960, 0);    // on the upper bound
    send_item(OpMeasure, 16'sd3840, 0);    // on the lower bound
    send_item(OpMeasure, 16'sd8961, 0);
    send_item(OpMeasure, 16'sd10239, 0);
    send_item(OpMeasure, 16'sd10240, 0);   // moderate, alarm fires
    send_item(OpMeasure, 16'sd11519, 0);
    send_item(OpMeasure, 16'sd11520, 0);   // critical
    send_item(OpMeasure, 16'sd2560, 0);
    send_item(OpMeasure, 16'sd1280, 0);
    send_item(OpMeasure, 16'sh7FFF, 0);
    send_item(OpMeasure, 16'sh8000, 0);
    send_item(OpMeasure, 16'sd8960, 0);    // repeated temperature
    send_item(OpMeasure, 16'sd8960, 0);
    send_item(OpReport, 16'shFFFF, 0);

    // inverted band, alarm on any alert, long sample period
    set_thresholds(35, 15, 0, 3600);
    send_item(OpMeasure, 16'sd6000, 0);
    send_item(OpMeasure, 16'sd3000, 0);
    send_item(OpMeasure, 16'sd3840, 0);
    send_item(OpMeasure, 16'sd9000, 0);
    send_item(OpReport, 16'sh5A5A, 0);

    set_thresholds(-128, 127, 0, 0);
    random_phase(320);
    set_thresholds(127, -128, 65535, 3600);
    random_phase(320);
    repeat (4) begin
      cur_low = int'($urandom_range(0, 60)) - 30;
      set_thresholds(cur_low, cur_low + int'($urandom_range(0, 30)),
                     $urandom_range(0, 6), $urandom_range(0, 3600));
      random_phase(310);
    end

    settle();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/tam_pkg.sv
hw/rtl/tam_front.sv
hw/rtl/tam_queue.sv
hw/rtl/tam_back.sv
hw/rtl/temperature_alert_monitor.sv
bench/tam_result_checker.sv
bench/tb_temperature_alert_monitor.sv
